### sv/text_console_cursor_scroll_top_defines.svh
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_top_defines
// Assertion macros shared by the console checker.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_TOP_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_TOP_DEFINES_SVH

// Plain clocked property, off during reset.
`define TCCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication with the consequent in the same cycle.
`define TCCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication with the consequent in the next cycle.
`define TCCS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/tccs_pkg.sv
// ----------------------------------------------------------------------------
// tccs_pkg
// Geometry, codes and shared types of the text console engine.
// ----------------------------------------------------------------------------
package tccs_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int LOC_W  = 11;
  localparam int TAB_WIDTH = 8;

  localparam logic [15:0] BLANK_CELL = 16'h0F20;
  localparam logic [7:0]  ATTR_RESET = 8'h0F;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_FIRST = 8'h20;
  localparam logic [7:0] CH_LAST  = 8'h7F;

  localparam logic [1:0] ACT_PUT   = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [ADDR_W-1:0] ROW_STRIDE  = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] COPY_LAST   = ADDR_W'((ROWS - 1) * COLUMNS - 1);
  localparam logic [ADDR_W-1:0] BOTTOM_BASE = ADDR_W'((ROWS - 1) * COLUMNS);
  localparam logic [ADDR_W-1:0] CELL_LAST   = ADDR_W'(CELL_COUNT - 1);

  typedef logic [COL_W+1:0] col_ext_t;
  typedef logic [ROW_W:0]   row_ext_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_DRAIN,
    ST_FILL
  } state_t;

  // Cursor update for one put-character word.
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             store;
    logic             scroll;
  } cur_upd_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(row) * ROW_STRIDE + ADDR_W'(col);
  endfunction

endpackage

### sv/tccs_cell_ram.sv
// ----------------------------------------------------------------------------
// tccs_cell_ram
// Cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tccs_cell_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [tccs_pkg::ADDR_W-1:0] waddr,
  input  logic [15:0]                wdata,
  input  logic [tccs_pkg::ADDR_W-1:0] raddr,
  output logic [15:0]                rdata
);

  logic [15:0] cell_mem [tccs_pkg::CELL_COUNT];
  logic [15:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      cell_mem[waddr] <= wdata;
    end
    rdata_r <= cell_mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/tccs_cursor.sv
// ----------------------------------------------------------------------------
// tccs_cursor
// Next cursor position for one character, with wrap and scroll detect.
// ----------------------------------------------------------------------------
module tccs_cursor (
  input  logic [tccs_pkg::COL_W-1:0] col,
  input  logic [tccs_pkg::ROW_W-1:0] row,
  input  logic [7:0]                 char_code,
  output tccs_pkg::cur_upd_t         upd
);

  tccs_pkg::col_ext_t col_t;
  tccs_pkg::row_ext_t row_t;
  logic               store;
  logic               scroll;

  always_comb begin
    col_t  = tccs_pkg::col_ext_t'(col);
    row_t  = tccs_pkg::row_ext_t'(row);
    store  = 1'b0;
    scroll = 1'b0;
    case (char_code)
      tccs_pkg::CH_BS: begin
        if (col_t != '0) begin
          col_t = col_t - 1'b1;
        end
      end
      tccs_pkg::CH_TAB: begin
        col_t = (col_t + tccs_pkg::col_ext_t'(tccs_pkg::TAB_WIDTH))
              & ~tccs_pkg::col_ext_t'(tccs_pkg::TAB_WIDTH - 1);
      end
      tccs_pkg::CH_CR: begin
        col_t = '0;
      end
      tccs_pkg::CH_LF: begin
        col_t = '0;
        row_t = row_t + 1'b1;
      end
      default: begin
        if (char_code >= tccs_pkg::CH_FIRST && char_code <= tccs_pkg::CH_LAST) begin
          store = 1'b1;
          col_t = col_t + 1'b1;
        end
      end
    endcase
    // wrap past the last column
    if (col_t >= tccs_pkg::col_ext_t'(tccs_pkg::COLUMNS)) begin
      col_t = '0;
      row_t = row_t + 1'b1;
    end
    // past the last row: pin to the bottom and request a scroll
    if (row_t >= tccs_pkg::row_ext_t'(tccs_pkg::ROWS)) begin
      scroll = 1'b1;
      row_t  = tccs_pkg::row_ext_t'(tccs_pkg::ROWS - 1);
    end
    upd.col    = col_t[tccs_pkg::COL_W-1:0];
    upd.row    = row_t[tccs_pkg::ROW_W-1:0];
    upd.store  = store;
    upd.scroll = scroll;
  end

endmodule

### sv/text_console_cursor_scroll_top.sv
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_top
// 80x25 text console: cell store in block RAM, cursor, wrap and scroll.
// ----------------------------------------------------------------------------
// Usage:
//   Input words are commands: drive in_action, in_char_code and in_cell_index
//   with start high; the word is taken at the edge where busy is low.
//   Every word gives exactly one result, shown for one cycle with out_strobe
//   high; the receiver cannot stall, so it must take the word on that cycle.
//   Results carry the cursor location after the command and, for a read,
//   the cell contents (zero for any other command or an out-of-range index).
// Timing per command:
//   put character without scroll, unused action: result in the cycle after
//     accept, busy stays low, one word per cycle.
//   read cell: RAM read register, then result register; busy in ST_READ.
//   put character that scrolls: rows copied up cell by cell through the
//     single RAM port pair, a drain state, bottom-row blanking, all busy.
//   clear screen: blank writes to all CELL_COUNT cells, busy throughout.
//   The cell RAM's one write port serializes these sweeps.
// Reset:
//   rst_n low homes the cursor and loads the attribute with 0x0F; after it
//   the block runs a blanking pass over all cells with busy high and no result.
//   cfg_wr_en writes the attribute at any idle edge.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_char_code,
  input  logic [10:0] in_cell_index,
  output logic        out_strobe,
  output logic [10:0] out_cursor_location,
  output logic [15:0] out_cell_data,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_color_attribute
);

  tccs_pkg::state_t state_r, state_nxt;

  logic [tccs_pkg::ADDR_W-1:0] cnt_r, cnt_nxt;
  logic [tccs_pkg::ADDR_W-1:0] pend_addr_r;
  logic                        pend_r;
  logic                        emit_r, emit_nxt;
  logic                        rd_ok_r;
  logic [tccs_pkg::COL_W-1:0]  col_r, col_nxt;
  logic [tccs_pkg::ROW_W-1:0]  row_r, row_nxt;
  logic [7:0]                  attr_r;
  logic                        stb_r, stb_nxt;
  logic [10:0]                 loc_r;
  logic [15:0]                 data_r, data_nxt;

  logic                        accept;
  logic                        fill_done;
  tccs_pkg::cur_upd_t          upd;

  logic                        ram_we;
  logic [tccs_pkg::ADDR_W-1:0] ram_waddr;
  logic [15:0]                 ram_wdata;
  logic [tccs_pkg::ADDR_W-1:0] ram_raddr;
  logic [15:0]                 ram_rdata;

  assign busy      = (state_r != tccs_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign fill_done = (cnt_r == tccs_pkg::CELL_LAST);

  tccs_cursor u_cursor (
    .col       (col_r),
    .row       (row_r),
    .char_code (in_char_code),
    .upd       (upd)
  );

  tccs_cell_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tccs_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_action)
            tccs_pkg::ACT_PUT:   state_nxt = upd.scroll ? tccs_pkg::ST_COPY
                                                        : tccs_pkg::ST_IDLE;
            tccs_pkg::ACT_CLEAR: state_nxt = tccs_pkg::ST_FILL;
            tccs_pkg::ACT_READ:  state_nxt = tccs_pkg::ST_READ;
            default:             state_nxt = tccs_pkg::ST_IDLE;
          endcase
        end
      end
      tccs_pkg::ST_READ:  state_nxt = tccs_pkg::ST_IDLE;
      tccs_pkg::ST_COPY: begin
        if (cnt_r == tccs_pkg::COPY_LAST) begin
          state_nxt = tccs_pkg::ST_DRAIN;
        end
      end
      tccs_pkg::ST_DRAIN: state_nxt = tccs_pkg::ST_FILL;
      tccs_pkg::ST_FILL: begin
        if (fill_done) begin
          state_nxt = tccs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tccs_pkg::ST_IDLE;
    endcase
  end

  // RAM port control: the copy write-back of the previous read wins; it
  // only happens in the cycle after a copy read, never during fill or idle
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_r;
    ram_wdata = tccs_pkg::BLANK_CELL;
    ram_raddr = tccs_pkg::ADDR_W'(in_cell_index);
    unique case (state_r)
      tccs_pkg::ST_IDLE: begin
        if (accept && in_action == tccs_pkg::ACT_PUT && upd.store) begin
          ram_we    = 1'b1;
          ram_waddr = tccs_pkg::cell_addr(row_r, col_r);
          ram_wdata = {attr_r, in_char_code};
        end
      end
      tccs_pkg::ST_COPY: begin
        ram_raddr = cnt_r + tccs_pkg::ROW_STRIDE;
      end
      tccs_pkg::ST_FILL: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
    if (pend_r) begin
      ram_we    = 1'b1;
      ram_waddr = pend_addr_r;
      ram_wdata = ram_rdata;
    end
  end

  // cursor, sweep counter and result
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    cnt_nxt  = cnt_r;
    emit_nxt = emit_r;
    stb_nxt  = 1'b0;
    data_nxt = '0;
    unique case (state_r)
      tccs_pkg::ST_IDLE: begin
        if (accept) begin
          cnt_nxt = '0;
          unique case (in_action)
            tccs_pkg::ACT_PUT: begin
              col_nxt  = upd.col;
              row_nxt  = upd.row;
              stb_nxt  = !upd.scroll;
              emit_nxt = upd.scroll;
            end
            tccs_pkg::ACT_CLEAR: begin
              col_nxt  = '0;
              row_nxt  = '0;
              emit_nxt = 1'b1;
            end
            tccs_pkg::ACT_READ: begin
              emit_nxt = 1'b0;
            end
            default: begin
              stb_nxt = 1'b1;
            end
          endcase
        end
      end
      tccs_pkg::ST_READ: begin
        stb_nxt  = 1'b1;
        data_nxt = rd_ok_r ? ram_rdata : 16'h0000;
      end
      tccs_pkg::ST_COPY: begin
        cnt_nxt = (cnt_r == tccs_pkg::COPY_LAST) ? tccs_pkg::BOTTOM_BASE
                                                 : cnt_r + 1'b1;
      end
      tccs_pkg::ST_DRAIN: begin
        cnt_nxt = cnt_r;
      end
      tccs_pkg::ST_FILL: begin
        cnt_nxt = cnt_r + 1'b1;
        if (fill_done) begin
          stb_nxt  = emit_r;
          emit_nxt = 1'b0;
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tccs_pkg::ST_FILL;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
      emit_r  <= 1'b0;
      col_r   <= '0;
      row_r   <= '0;
      attr_r  <= tccs_pkg::ATTR_RESET;
      stb_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= (state_r == tccs_pkg::ST_COPY);
      emit_r  <= emit_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      stb_r   <= stb_nxt;
      if (cfg_wr_en) begin
        attr_r <= cfg_color_attribute;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_addr_r <= cnt_r;
    if (accept) begin
      rd_ok_r <= (32'(in_cell_index) < 32'(tccs_pkg::CELL_COUNT));
    end
    if (stb_nxt) begin
      loc_r  <= 11'(tccs_pkg::cell_addr(row_nxt, col_nxt));
      data_r <= data_nxt;
    end
  end

  assign out_strobe          = stb_r;
  assign out_cursor_location = loc_r;
  assign out_cell_data       = data_r;

endmodule

### sv/tccs_checker.sv
// ----------------------------------------------------------------------------
// tccs_checker
// Port-level checks of the text console, bound to the top level.
// ----------------------------------------------------------------------------
`include "text_console_cursor_scroll_top_defines.svh"

module tccs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_action,
  input logic        out_strobe,
  input logic [10:0] out_cursor_location
);

  logic loc_on_screen;
  logic clear_taken;

  assign loc_on_screen = (32'(out_cursor_location) < 32'(tccs_pkg::CELL_COUNT));
  assign clear_taken   = start && !busy && (in_action == tccs_pkg::ACT_CLEAR);

  // an accepted word either answers at once or holds the block busy
  `TCCS_ASSERT_NXT(a_accept_answers, start && !busy, out_strobe || busy, "no answer, not busy")

  // a result only follows an accepted word or a busy period
  `TCCS_ASSERT_IMP(a_no_stray_result, out_strobe, $past(start || busy), "result without a word")

  // cursor stays on screen
  `TCCS_ASSERT_IMP(a_cursor_range, out_strobe, loc_on_screen, "cursor off screen")

  // every result shows with the block back in idle
  `TCCS_ASSERT(a_idle_on_result, !(out_strobe && busy), "result while busy")

  // a clear always starts a blanking sweep
  `TCCS_ASSERT_NXT(a_clear_busy, clear_taken, busy, "clear without sweep")

endmodule

bind text_console_cursor_scroll_top tccs_checker u_tccs_checker (.*);

### verif/tb_text_console_cursor_scroll_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_cursor_scroll_top
// Self-checking bench for the text console. A cycle-free mirror of the cell
// store, cursor and attribute predicts every result word. The bench drives
// put, clear, read and unused commands, with directed edge cases first and
// then random text, and checks each strobed result against the mirror.
// ----------------------------------------------------------------------------

import tccs_pkg::*;

typedef struct {
  logic [LOC_W-1:0] loc;
  logic [15:0]      data;
} console_word_t;

class console_mirror;
  logic [15:0]   cells [CELL_COUNT];
  int unsigned   col;
  int unsigned   row;
  logic [7:0]    attr;
  console_word_t expected_words [$];
  int unsigned   mismatches;

  function new();
    blank_all();
    attr = ATTR_RESET;
    mismatches = 0;
  endfunction

  function void blank_all();
    foreach (cells[i]) cells[i] = BLANK_CELL;
    col = 0;
    row = 0;
  endfunction

  function void set_attr(logic [7:0] value);
    attr = value;
  endfunction

  function int unsigned cursor_index();
    return row * COLUMNS + col;
  endfunction

  function void apply_put(logic [7:0] ch);
    if (ch == CH_BS) begin
      if (col != 0) col--;
    end else if (ch == CH_TAB) begin
      col = (col / TAB_WIDTH + 1) * TAB_WIDTH;
    end else if (ch == CH_CR) begin
      col = 0;
    end else if (ch == CH_LF) begin
      col = 0;
      row++;
    end else if (ch >= CH_FIRST && ch <= CH_LAST) begin
      cells[row * COLUMNS + col] = {attr, ch};
      col++;
    end
    if (col >= COLUMNS) begin
      col = 0;
      row++;
    end
    // Scroll: shift every row up, blank the bottom one with the fixed blank.
    if (row >= ROWS) begin
      for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) cells[i] = cells[i + COLUMNS];
      for (int i = (ROWS - 1) * COLUMNS; i < CELL_COUNT; i++) cells[i] = BLANK_CELL;
      row = ROWS - 1;
    end
  endfunction

  function void note_command(logic [1:0] act, logic [7:0] ch, logic [10:0] idx);
    console_word_t w;
    w.data = '0;
    case (act)
      ACT_PUT:   apply_put(ch);
      ACT_CLEAR: blank_all();
      ACT_READ:  if (idx < CELL_COUNT) w.data = cells[idx];
      default:   ;
    endcase
    w.loc = LOC_W'(cursor_index());
    expected_words.push_back(w);
  endfunction

  task report(string what);
    mismatches++;
    if (mismatches <= 40) $display("tb: mismatch %0d: %s", mismatches, what);
  endtask

  task check_word(logic [LOC_W-1:0] loc, logic [15:0] data);
    console_word_t w;
    if (expected_words.size() == 0) begin
      report($sformatf("result with nothing pending: loc=%0d data=%h", loc, data));
    end else begin
      w = expected_words.pop_front();
      if (loc !== w.loc)
        report($sformatf("cursor location: got %0d, want %0d", loc, w.loc));
      if (data !== w.data)
        report($sformatf("cell data: got %h, want %h", data, w.data));
    end
  endtask
endclass

module tb_text_console_cursor_scroll_top;

  localparam int HALF_PERIOD     = 10;
  localparam int WATCHDOG_LIMIT  = 8000;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 134;

  // Unused command code, and a few character bytes for the directed part.
  localparam logic [1:0] ACT_NONE    = 2'd3;
  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_US       = 8'h1F;
  localparam logic [7:0] CH_HIGH     = 8'h80;
  localparam logic [7:0] CH_TOP      = 8'hFF;
  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] ATTR_ZERO   = 8'h00;
  localparam logic [7:0] ATTR_ONES   = 8'hFF;
  localparam logic [10:0] IDX_MAX    = 11'h7FF;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_action;
  logic [7:0]  in_char_code;
  logic [10:0] in_cell_index;
  logic        out_strobe;
  logic [10:0] out_cursor_location;
  logic [15:0] out_cell_data;
  logic        cfg_wr_en;
  logic [7:0]  cfg_color_attribute;

  console_mirror shadow;
  int unsigned   words_taken;
  int unsigned   stall_cycles;
  bit            sender_gaps;
  bit            quiet;

  text_console_cursor_scroll_top u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_action           (in_action),
    .in_char_code        (in_char_code),
    .in_cell_index       (in_cell_index),
    .out_strobe          (out_strobe),
    .out_cursor_location (out_cursor_location),
    .out_cell_data       (out_cell_data),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_color_attribute (cfg_color_attribute)
  );

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // Sample at the rising edge. Check the result first so a word taken on
  // the same edge never matches its own expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) shadow.check_word(out_cursor_location, out_cell_data);
      if (start && !busy) begin
        shadow.note_command(in_action, in_char_code, in_cell_index);
        words_taken++;
      end
      if (cfg_wr_en) shadow.set_attr(cfg_color_attribute);
    end
  end

  // Watchdog: count edges at which no word moves on either side. A scroll or
  // clear stalls for a whole RAM sweep, as does the blanking pass after reset.
  always @(posedge clk) begin
    if ((rst_n && start && !busy) || out_strobe) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Drive one command word and hold it until the block takes it.
  task automatic send_word(input logic [1:0] act, input logic [7:0] ch,
                           input logic [10:0] idx);
    int unsigned target;
    target        = words_taken + 1;
    start         = 1'b1;
    in_action     = act;
    in_char_code  = ch;
    in_cell_index = idx;
    @(negedge clk);
    while (words_taken < target) @(negedge clk);
    start = 1'b0;
  endtask

  // Drop start for a short burst, with noise on the fields.
  task automatic sender_gap();
    int n;
    if (sender_gaps && !quiet && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        in_action     = 2'($urandom);
        in_char_code  = 8'($urandom);
        in_cell_index = 11'($urandom);
        @(negedge clk);
      end
    end
  endtask

  // Wait for every pending result, then for the block to drop busy.
  task automatic wait_idle();
    while (shadow.expected_words.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic write_attr(input logic [7:0] value);
    wait_idle();
    cfg_wr_en           = 1'b1;
    cfg_color_attribute = value;
    @(negedge clk);
    cfg_wr_en           = 1'b0;
    cfg_color_attribute = 8'($urandom);
  endtask

  // Mostly text: printable runs broken by newlines, tabs and backspaces, reads
  // near the cursor or out of range, ignored bytes, unused words, the odd clear.
  task automatic send_random();
    int unsigned pick;
    int unsigned here;
    logic [1:0]  act;
    logic [7:0]  ch;
    logic [10:0] idx;
    pick = $urandom_range(0, 199);
    act  = ACT_PUT;
    ch   = 8'($urandom);
    idx  = 11'($urandom);
    if (pick < 96) begin
      ch = 8'($urandom_range(CH_FIRST, CH_LAST));
    end else if (pick < 120) begin
      ch = CH_LF;
    end else if (pick < 128) begin
      ch = CH_CR;
    end else if (pick < 138) begin
      ch = CH_TAB;
    end else if (pick < 148) begin
      ch = CH_BS;
    end else if (pick < 156) begin
      ch = $urandom_range(0, 1) ? 8'($urandom_range(CH_HIGH, CH_TOP))
                                : 8'($urandom_range(CH_NUL, CH_US));
    end else if (pick < 192) begin
      act  = ACT_READ;
      here = shadow.cursor_index();
      case ($urandom_range(0, 3))
        0:       idx = 11'((here + CELL_COUNT - $urandom_range(1, 3)) % CELL_COUNT);
        1:       idx = 11'($urandom_range(CELL_COUNT, IDX_MAX));
        default: idx = 11'($urandom_range(0, CELL_COUNT - 1));
      endcase
    end else if (pick < 198) begin
      act = ACT_NONE;
    end else if ($urandom_range(0, 1) == 0) begin
      act = ACT_CLEAR;
    end
    send_word(act, ch, idx);
  endtask

  initial begin
    logic [7:0] attr_value;
    shadow              = new();
    words_taken         = 0;
    stall_cycles        = 0;
    sender_gaps         = 1'b0;
    quiet               = 1'b0;
    rst_n               = 1'b0;
    start               = 1'b0;
    in_action           = ACT_PUT;
    in_char_code        = CH_NUL;
    in_cell_index       = '0;
    cfg_wr_en           = 1'b0;
    cfg_color_attribute = ATTR_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset blank, printable limits, ignored bytes, each control
    // code, backspace at the left edge, read range limits, unused command
    // and clear. The attribute still holds its reset value here.
    send_word(ACT_READ,  CH_NUL,     '0);
    send_word(ACT_PUT,   CH_UPPER_A, IDX_MAX);
    send_word(ACT_PUT,   CH_FIRST,   '0);
    send_word(ACT_PUT,   CH_LAST,    '0);
    send_word(ACT_PUT,   CH_HIGH,    '0);
    send_word(ACT_PUT,   CH_TOP,     '0);
    send_word(ACT_PUT,   CH_NUL,     '0);
    send_word(ACT_PUT,   CH_US,      '0);
    send_word(ACT_PUT,   CH_BS,      '0);
    send_word(ACT_PUT,   CH_TAB,     '0);
    send_word(ACT_PUT,   CH_TAB,     '0);
    send_word(ACT_PUT,   CH_CR,      '0);
    send_word(ACT_PUT,   CH_BS,      '0);
    send_word(ACT_PUT,   CH_LF,      '0);
    send_word(ACT_READ,  CH_TOP,     11'd0);
    send_word(ACT_READ,  CH_NUL,     11'd2);
    send_word(ACT_READ,  CH_NUL,     11'(CELL_COUNT - 1));
    send_word(ACT_READ,  CH_NUL,     11'(CELL_COUNT));
    send_word(ACT_READ,  CH_NUL,     IDX_MAX);
    send_word(ACT_NONE,  CH_UPPER_A, IDX_MAX);
    send_word(ACT_CLEAR, CH_TOP,     IDX_MAX);
    send_word(ACT_READ,  CH_NUL,     11'd0);

    // Random phases, each under its own attribute: both extremes first.
    // Hold the sender steady through the final phase.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       attr_value = ATTR_ZERO;
        1:       attr_value = ATTR_ONES;
        default: attr_value = 8'($urandom);
      endcase
      write_attr(attr_value);
      sender_gaps = (p != PHASES - 1);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if ($urandom_range(0, 31) == 0) quiet = !quiet;
        send_random();
        sender_gap();
      end
    end

    wait_idle();
    repeat (10) @(negedge clk);
    if (shadow.expected_words.size() != 0)
      shadow.report($sformatf("%0d results never arrived", shadow.expected_words.size()));
    if (shadow.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
